// File: hw/rtl/cau_pkg.sv
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5,
    OP_POW  = 3'd6,
    OP_NOP  = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // what the product sequence feeds: complex product, quotient, magnitude
  typedef enum logic [1:0] {
    K_MUL,
    K_DIV,
    K_MAG
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_POST,
    S_DIV_WAIT,
    S_SQRT,
    S_FIN
  } state_e;

  // classified request, as the front hands it to the queue
  typedef struct packed {
    op_e        op;
    logic       exp_neg;
    logic [7:0] exp_mag;
  } cls_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: hw/rtl/cau_front.sv
module cau_front (
  input  logic              start_i,
  input  logic [2:0]        opcode_i,
  input  logic signed [7:0] exponent_i,
  input  logic              full_i,
  output logic              busy_o,
  output logic              push_o,
  output cau_pkg::cls_t     cls_o
);

  logic [7:0] exp_raw;

  assign exp_raw = exponent_i;
  assign busy_o  = full_i;
  assign push_o  = start_i && !full_i;

  always_comb begin
    cls_o.op      = cau_pkg::op_e'(opcode_i);
    cls_o.exp_neg = exp_raw[7];
    cls_o.exp_mag = exp_raw[7] ? (~exp_raw + 8'd1) : exp_raw;
  end

endmodule

// File: hw/rtl/cau_fifo.sv
module cau_fifo #(
  parameter int DATA_W = 136,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PtrW'(DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PtrW'(DEPTH - 1)) ? '0 : rp_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

// File: hw/rtl/cau_mul.sv
module cau_mul #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        x_i,
  input  logic [W-1:0]        y_i,
  output cau_pkg::unit_stat_t stat_o,
  output logic [2*W-1:0]      p_o
);

  localparam int CntW = $clog2(W + 1);

  logic [2*W-1:0] mcand_q, mcand_d, p_q, p_d;
  logic [W-1:0]   mplier_q, mplier_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;

  // shift-add, one multiplier bit per cycle
  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    p_d      = p_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i && !busy_q) begin
      mcand_d  = {{W{1'b0}}, x_i};
      mplier_d = y_i;
      p_d      = '0;
      cnt_d    = CntW'(W);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        p_d = p_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    p_q      <= p_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = p_q;

endmodule

// File: hw/rtl/cau_div.sv
module cau_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2*W:0]        num_i,
  input  logic [2*W:0]        den_i,
  output cau_pkg::unit_stat_t stat_o,
  output logic [W:0]          q_o,
  output logic                ovf_o
);

  localparam int NumW  = 2 * W + 1;
  localparam int DenW  = 2 * W + 1;
  localparam int QW    = W + 1;
  localparam int Steps = NumW + F;
  localparam int CntW  = $clog2(Steps + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d, rem_q, rem_d;
  logic [QW-1:0]   q_q, q_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   shifted, diff;

  // restoring division of num * 2^F by den, one quotient bit per cycle;
  // quotient bits beyond QW only mark overflow
  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    q_d     = q_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, num_q[NumW-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i && !busy_q) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      q_d    = '0;
      ovf_d  = 1'b0;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = diff[DenW] ? shifted[DenW-1:0] : diff[DenW-1:0];
      if (q_q[QW-1]) begin
        ovf_d = 1'b1;
      end
      q_d   = {q_q[QW-2:0], !diff[DenW]};
      num_d = num_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o         = q_q;
  assign ovf_o       = ovf_q;

endmodule

// File: hw/rtl/cau_back.sv
module cau_back #(
  parameter int W    = 32,
  parameter int F    = 16,
  parameter int MAXE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  logic [4*W+$bits(cau_pkg::cls_t)-1:0] data_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [W-1:0]        res_re_o,
  output logic [W-1:0]        res_im_o,
  output logic [1:0]          status_o
);

  localparam int AW   = 2 * W + 2;
  localparam int CW   = $clog2(MAXE + 1);
  localparam int NW   = (CW > 8) ? CW : 8;
  localparam int SqW  = $clog2(W + 1);
  localparam int RW   = W + 2;
  localparam logic [AW-1:0] LimPos = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [AW-1:0] LimNeg = {{(AW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  Unit   = {{(W-1){1'b0}}, 1'b1} << F;

  // clamp a sign-magnitude value to the word; bit W flags overflow
  function automatic logic [W:0] sat_fn(input logic [AW-1:0] mag, input logic neg);
    logic [AW-1:0] lim;
    logic [AW-1:0] m;
    logic [W-1:0]  v;
    lim = neg ? LimNeg : LimPos;
    m   = (mag > lim) ? lim : mag;
    v   = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    return {(mag > lim), v};
  endfunction

  function automatic logic [W:0] satw_fn(input logic [W:0] s);
    logic ovf;
    ovf = s[W] ^ s[W-1];
    if (ovf) begin
      return {1'b1, s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W-1:0] mag_fn(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  cau_pkg::cls_t  cls;
  logic [W-1:0]   in_are, in_aim, in_bre, in_bim;

  cau_pkg::state_e state_q, state_d;
  cau_pkg::kind_e  kind_q, kind_d;
  logic [2:0]      k_q, k_d;
  logic            pow_q, pow_d, im_ph_q, im_ph_d, done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      st_q, st_d;
  logic [W-1:0]    opa_re_q, opa_re_d, opa_im_q, opa_im_d;
  logic [W-1:0]    opb_re_q, opb_re_d, opb_im_q, opb_im_d;
  logic [W-1:0]    base_re_q, base_re_d, base_im_q, base_im_d;
  logic [W-1:0]    res_re_q, res_re_d, res_im_q, res_im_d;
  logic signed [AW-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [2*W:0]    acc_d_q, acc_d_d;
  logic [2*W-1:0]  sq_src_q, sq_src_d;
  logic [RW-1:0]   sq_rem_q, sq_rem_d;
  logic [W-1:0]    sq_root_q, sq_root_d;
  logic [SqW-1:0]  sq_cnt_q, sq_cnt_d;

  logic [W-1:0]    ar, ai, br, bi, mx, my;
  logic            sar, sai, sbr, sbi, pneg, last;
  logic [NW-1:0]   pow_n;
  logic            mul_start, div_start;
  cau_pkg::unit_stat_t mul_stat, div_stat;
  logic [2*W-1:0]  mul_p;
  logic [W:0]      div_q;
  logic            div_ovf;
  logic [2*W:0]    div_num;

  assign {cls, in_are, in_aim, in_bre, in_bim} = data_i;

  assign ar  = mag_fn(opa_re_q);
  assign ai  = mag_fn(opa_im_q);
  assign br  = mag_fn(opb_re_q);
  assign bi  = mag_fn(opb_im_q);
  assign sar = opa_re_q[W-1];
  assign sai = opa_im_q[W-1];
  assign sbr = opb_re_q[W-1];
  assign sbi = opb_im_q[W-1];

  assign pow_n = (NW'(cls.exp_mag) > NW'(MAXE)) ? NW'(MAXE) : NW'(cls.exp_mag);
  assign last  = (kind_q == cau_pkg::K_MUL) ? (k_q == 3'd3) : (k_q == 3'd5);

  // product list: four cross products, then two squares
  always_comb begin
    unique case (k_q)
      3'd0: begin mx = ar; my = br; pneg = sar ^ sbr; end
      3'd1: begin mx = ai; my = bi; pneg = sai ^ sbi; end
      3'd2: begin mx = ar; my = bi; pneg = sar ^ sbi; end
      3'd3: begin mx = ai; my = br; pneg = sai ^ sbr; end
      3'd4: begin
        mx = (kind_q == cau_pkg::K_MAG) ? ar : br;
        my = mx;
        pneg = 1'b0;
      end
      3'd5: begin
        mx = (kind_q == cau_pkg::K_MAG) ? ai : bi;
        my = mx;
        pneg = 1'b0;
      end
      default: begin mx = ar; my = br; pneg = 1'b0; end
    endcase
  end

  assign div_num = im_ph_q ? (acc_im_q[AW-1] ? (2*W+1)'(-acc_im_q) : (2*W+1)'(acc_im_q))
                           : (acc_re_q[AW-1] ? (2*W+1)'(-acc_re_q) : (2*W+1)'(acc_re_q));

  cau_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mx),
    .y_i     (my),
    .stat_o  (mul_stat),
    .p_o     (mul_p)
  );

  cau_div #(.W(W), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (acc_d_q),
    .stat_o  (div_stat),
    .q_o     (div_q),
    .ovf_o   (div_ovf)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cau_pkg::S_IDLE: begin
        if (!empty_i) begin
          unique case (cls.op)
            cau_pkg::OP_MUL, cau_pkg::OP_DIV, cau_pkg::OP_MAG: state_d = cau_pkg::S_MUL_GO;
            cau_pkg::OP_POW: begin
              if (pow_n == '0) begin
                state_d = cau_pkg::S_IDLE;
              end else if (cls.exp_neg) begin
                state_d = cau_pkg::S_MUL_GO;
              end else begin
                state_d = cau_pkg::S_FIN;
              end
            end
            default: state_d = cau_pkg::S_IDLE;
          endcase
        end
      end
      cau_pkg::S_MUL_GO: state_d = cau_pkg::S_MUL_WAIT;
      cau_pkg::S_MUL_WAIT: begin
        if (mul_stat.done) begin
          if (!last) begin
            state_d = cau_pkg::S_MUL_GO;
          end else if (kind_q == cau_pkg::K_MUL) begin
            state_d = cau_pkg::S_FIN;
          end else begin
            state_d = cau_pkg::S_POST;
          end
        end
      end
      cau_pkg::S_POST: begin
        if (kind_q == cau_pkg::K_MAG) begin
          state_d = cau_pkg::S_SQRT;
        end else if (acc_d_q == '0) begin
          state_d = cau_pkg::S_FIN;
        end else begin
          state_d = cau_pkg::S_DIV_WAIT;
        end
      end
      cau_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = im_ph_q ? cau_pkg::S_FIN : cau_pkg::S_POST;
        end
      end
      cau_pkg::S_SQRT: begin
        if (sq_cnt_q == SqW'(1)) begin
          state_d = cau_pkg::S_FIN;
        end
      end
      cau_pkg::S_FIN: begin
        state_d = (pow_q && cnt_q != '0) ? cau_pkg::S_MUL_GO : cau_pkg::S_IDLE;
      end
      default: state_d = cau_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = (state_q == cau_pkg::S_IDLE) && !empty_i;
    mul_start = (state_q == cau_pkg::S_MUL_GO);
    div_start = (state_q == cau_pkg::S_POST) && (kind_q == cau_pkg::K_DIV) &&
                (acc_d_q != '0);
  end

  // datapath
  always_comb begin
    logic [W:0]           sr, si;
    logic signed [AW-1:0] pe, term;
    logic [AW-1:0]        mre, mim;
    logic [RW+1:0]        rem2, trial;
    logic                 ge;
    kind_d    = kind_q;
    k_d       = k_q;
    pow_d     = pow_q;
    im_ph_d   = im_ph_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    st_d      = st_q;
    opa_re_d  = opa_re_q;
    opa_im_d  = opa_im_q;
    opb_re_d  = opb_re_q;
    opb_im_d  = opb_im_q;
    base_re_d = base_re_q;
    base_im_d = base_im_q;
    res_re_d  = res_re_q;
    res_im_d  = res_im_q;
    acc_re_d  = acc_re_q;
    acc_im_d  = acc_im_q;
    acc_d_d   = acc_d_q;
    sq_src_d  = sq_src_q;
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    sq_cnt_d  = sq_cnt_q;
    sr        = '0;
    si        = '0;
    pe        = AW'(mul_p);
    term      = pneg ? -pe : pe;
    mre       = '0;
    mim       = '0;
    rem2      = {sq_rem_q, sq_src_q[2*W-1:2*W-2]};
    trial     = {2'b00, sq_root_q, 2'b01};
    ge        = (rem2 >= trial);

    unique case (state_q)
      cau_pkg::S_IDLE: begin
        if (!empty_i) begin
          st_d     = cau_pkg::ST_OK;
          pow_d    = 1'b0;
          im_ph_d  = 1'b0;
          k_d      = 3'd0;
          acc_re_d = '0;
          acc_im_d = '0;
          acc_d_d  = '0;
          opa_re_d = in_are;
          opa_im_d = in_aim;
          opb_re_d = in_bre;
          opb_im_d = in_bim;
          unique case (cls.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ, cau_pkg::OP_NOP: begin
              unique case (cls.op)
                cau_pkg::OP_ADD: begin
                  sr = satw_fn({in_are[W-1], in_are} + {in_bre[W-1], in_bre});
                  si = satw_fn({in_aim[W-1], in_aim} + {in_bim[W-1], in_bim});
                end
                cau_pkg::OP_SUB: begin
                  sr = satw_fn({in_are[W-1], in_are} - {in_bre[W-1], in_bre});
                  si = satw_fn({in_aim[W-1], in_aim} - {in_bim[W-1], in_bim});
                end
                cau_pkg::OP_CONJ: begin
                  sr = {1'b0, in_are};
                  si = satw_fn({(W+1){1'b0}} - {in_aim[W-1], in_aim});
                end
                default: begin
                  sr = '0;
                  si = '0;
                end
              endcase
              res_re_d = sr[W-1:0];
              res_im_d = si[W-1:0];
              st_d     = (sr[W] || si[W]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
              done_d   = 1'b1;
            end
            cau_pkg::OP_MUL: kind_d = cau_pkg::K_MUL;
            cau_pkg::OP_DIV: kind_d = cau_pkg::K_DIV;
            cau_pkg::OP_MAG: begin
              kind_d = cau_pkg::K_MAG;
              k_d    = 3'd4;
            end
            cau_pkg::OP_POW: begin
              pow_d = 1'b1;
              cnt_d = CW'(pow_n - NW'(1));
              if (pow_n == '0) begin
                sr       = sat_fn(AW'(Unit), 1'b0);
                res_re_d = sr[W-1:0];
                res_im_d = '0;
                st_d     = sr[W] ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
                done_d   = 1'b1;
              end else if (cls.exp_neg) begin
                // reciprocal first: 1.0 / A
                kind_d   = cau_pkg::K_DIV;
                opa_re_d = Unit;
                opa_im_d = '0;
                opb_re_d = in_are;
                opb_im_d = in_aim;
              end else begin
                res_re_d  = in_are;
                res_im_d  = in_aim;
                base_re_d = in_are;
                base_im_d = in_aim;
              end
            end
          endcase
        end
      end
      cau_pkg::S_MUL_WAIT: begin
        if (mul_stat.done) begin
          unique case (k_q)
            3'd0: acc_re_d = acc_re_q + term;
            3'd1: acc_re_d = (kind_q == cau_pkg::K_DIV) ? acc_re_q + term : acc_re_q - term;
            3'd2: acc_im_d = (kind_q == cau_pkg::K_DIV) ? acc_im_q - term : acc_im_q + term;
            3'd3: acc_im_d = acc_im_q + term;
            default: acc_d_d = acc_d_q + {1'b0, mul_p};
          endcase
          k_d = k_q + 3'd1;
          if (last && kind_q == cau_pkg::K_MUL) begin
            mre      = (acc_re_d[AW-1] ? AW'(-acc_re_d) : AW'(acc_re_d)) >> F;
            mim      = (acc_im_d[AW-1] ? AW'(-acc_im_d) : AW'(acc_im_d)) >> F;
            sr       = sat_fn(mre, acc_re_d[AW-1]);
            si       = sat_fn(mim, acc_im_d[AW-1]);
            res_re_d = sr[W-1:0];
            res_im_d = si[W-1:0];
            if (sr[W] || si[W]) begin
              st_d = cau_pkg::ST_OVF;
            end
            if (pow_q) begin
              cnt_d = cnt_q - CW'(1);
            end
          end
        end
      end
      cau_pkg::S_POST: begin
        if (kind_q == cau_pkg::K_MAG) begin
          sq_src_d  = acc_d_q[2*W-1:0];
          sq_rem_d  = '0;
          sq_root_d = '0;
          sq_cnt_d  = SqW'(W);
        end else if (acc_d_q == '0) begin
          res_re_d = '0;
          res_im_d = '0;
          st_d     = cau_pkg::ST_DIV0;
          cnt_d    = '0;
        end
      end
      cau_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          mre = div_ovf ? '1 : AW'(div_q);
          sr  = sat_fn(mre, im_ph_q ? acc_im_q[AW-1] : acc_re_q[AW-1]);
          if (sr[W]) begin
            st_d = cau_pkg::ST_OVF;
          end
          if (im_ph_q) begin
            res_im_d  = sr[W-1:0];
            base_re_d = res_re_q;
            base_im_d = sr[W-1:0];
          end else begin
            res_re_d = sr[W-1:0];
            im_ph_d  = 1'b1;
          end
        end
      end
      cau_pkg::S_SQRT: begin
        sq_rem_d  = ge ? RW'(rem2 - trial) : RW'(rem2);
        sq_root_d = {sq_root_q[W-2:0], ge};
        sq_src_d  = sq_src_q << 2;
        sq_cnt_d  = sq_cnt_q - SqW'(1);
        if (sq_cnt_q == SqW'(1)) begin
          sr       = sat_fn(AW'(sq_root_d), 1'b0);
          res_re_d = sr[W-1:0];
          res_im_d = '0;
          if (sr[W]) begin
            st_d = cau_pkg::ST_OVF;
          end
        end
      end
      cau_pkg::S_FIN: begin
        if (pow_q && cnt_q != '0) begin
          opa_re_d = res_re_q;
          opa_im_d = res_im_q;
          opb_re_d = base_re_q;
          opb_im_d = base_im_q;
          kind_d   = cau_pkg::K_MUL;
          k_d      = 3'd0;
          acc_re_d = '0;
          acc_im_d = '0;
        end else begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cau_pkg::S_IDLE;
      kind_q  <= cau_pkg::K_MUL;
      k_q     <= '0;
      pow_q   <= 1'b0;
      im_ph_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      st_q    <= cau_pkg::ST_OK;
      sq_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      k_q     <= k_d;
      pow_q   <= pow_d;
      im_ph_q <= im_ph_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      sq_cnt_q <= sq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_re_q  <= opa_re_d;
    opa_im_q  <= opa_im_d;
    opb_re_q  <= opb_re_d;
    opb_im_q  <= opb_im_d;
    base_re_q <= base_re_d;
    base_im_q <= base_im_d;
    res_re_q  <= res_re_d;
    res_im_q  <= res_im_d;
    acc_re_q  <= acc_re_d;
    acc_im_q  <= acc_im_d;
    acc_d_q   <= acc_d_d;
    sq_src_q  <= sq_src_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
  end

  assign done_o   = done_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = st_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (st_q == cau_pkg::ST_OK || st_q == cau_pkg::ST_DIV0 ||
                st_q == cau_pkg::ST_OVF))
    else $error("result with undefined status");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && st_q == cau_pkg::ST_DIV0) |-> (res_re_q == '0 && res_im_q == '0))
    else $error("zero divisor result not cleared");

  a_mul_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule

// File: hw/rtl/complex_arithmetic_unit.sv
// Complex ALU on signed fixed point words (WORD_BITS wide, FRAC_BITS fraction
// bits). A request is taken when start is high and busy is low; requests wait
// in a two-entry queue, so busy rises only when two are already waiting. Each
// request yields exactly one result, shown for one cycle with done_o high; the
// receiver cannot stall it. Time per request is set by one shared shift-add
// multiplier and a one-bit-per-cycle divider. Add, sub, conjugate and the
// unused opcode finish in the cycle after leaving the queue; multiply runs
// four partial products; magnitude two squares plus a WORD_BITS-step square
// root; divide six products and then one division per component; power adds
// one multiply per extra factor, plus one divide for a negative exponent, up
// to MAX_EXPONENT factors. Results leave in request order.
// FRAC_BITS must stay below WORD_BITS-1 so that 1.0 is representable.
module complex_arithmetic_unit #(
  parameter int WORD_BITS    = 32,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_EXPONENT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  input  logic signed [7:0]           exponent_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic [1:0]                  status_o
);

  localparam int QDataW = 4 * WORD_BITS + $bits(cau_pkg::cls_t);

  cau_pkg::cls_t     cls;
  logic              push, pop, q_empty, q_full;
  logic [QDataW-1:0] q_wdata, q_rdata;
  logic [WORD_BITS-1:0] res_re, res_im;

  // front: takes the request and decodes opcode and exponent
  cau_front u_front (
    .start_i    (start),
    .opcode_i   (opcode_i),
    .exponent_i (exponent_i),
    .full_i     (q_full),
    .busy_o     (busy),
    .push_o     (push),
    .cls_o      (cls)
  );

  assign q_wdata = {cls, a_re_i, a_im_i, b_re_i, b_im_i};

  // request queue between front and back
  cau_fifo #(.DATA_W(QDataW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: product sequencer, divider and square root
  cau_back #(.W(WORD_BITS), .F(FRAC_BITS), .MAXE(MAX_EXPONENT)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .data_i   (q_rdata),
    .pop_o    (pop),
    .done_o   (done_o),
    .res_re_o (res_re),
    .res_im_o (res_im),
    .status_o (status_o)
  );

  assign res_re_o = res_re;
  assign res_im_o = res_im;

endmodule
